// File: rtl/core/sctq_pkg.sv
// shared types, constants and helper functions of the scaled clock event timer queue
package sctq_pkg;

    // sizes of the event queue and tag store
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // command queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // field widths
    localparam int TIME_W      = 48;
    localparam int DELTA_W     = 24;
    localparam int SCALE_W     = 16;
    localparam int TAG_W       = 16;
    localparam int PROD_W      = DELTA_W + SCALE_W;
    localparam int STEP_W      = PROD_W - 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // command codes
    localparam logic [1:0] OP_ADVANCE    = 2'd0;
    localparam logic [1:0] OP_POST_AT    = 2'd1;
    localparam logic [1:0] OP_POST_AFTER = 2'd2;
    localparam logic [1:0] OP_SET_TIME   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAUSED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE = 2'd2;

    // configuration reset values
    localparam logic [DELTA_W-1:0] MAX_DELTA_RST  = 24'd1092;
    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

    // input word
    typedef struct packed {
        logic [1:0]         opcode;
        logic [DELTA_W-1:0] delta_time;
        logic [TIME_W-1:0]  time_value;
        logic [TAG_W-1:0]   event_tag;
    } cmd_t;

    // result word
    typedef struct packed {
        logic              event_fired;
        logic [TAG_W-1:0]  fired_tag;
        logic [TIME_W-1:0] elapsed_now;
        logic [TIME_W-1:0] applied_delta;
        logic              status;
        logic              last;
    } res_t;

    // classified command held in the command queue
    typedef struct packed {
        logic [1:0]          opcode;
        logic [DELTA_W-1:0]  delta;
        logic [TIME_W-1:0]   time_value;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    // event queue controls from the back end
    typedef struct packed {
        logic ins;
        logic pop;
    } evq_ctrl_t;

    // event queue status seen by the back end
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic                full;
        logic [TIME_W-1:0]   head_time;
        logic [TAG_BITS-1:0] head_tag;
        logic [TIME_W-1:0]   next_time;
    } evq_view_t;

    // saturating 48-bit add
    function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // tag as stored in the queue
    function automatic logic [TAG_BITS-1:0] tag_store(input logic [TAG_W-1:0] t);
        logic [TAG_BITS+TAG_W-1:0] w;
        w = {{TAG_BITS{1'b0}}, t};
        return w[TAG_BITS-1:0];
    endfunction

    // stored tag as reported
    function automatic logic [TAG_W-1:0] tag_out(input logic [TAG_BITS-1:0] t);
        logic [TAG_BITS+TAG_W-1:0] w;
        w = {{TAG_W{1'b0}}, t};
        return w[TAG_W-1:0];
    endfunction

endpackage

// File: rtl/core/sctq_front.sv
// front end: configuration registers, command accept, delta clamp and tag masking
module sctq_front import sctq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cmd_t                  s_data,
    input  logic                  fifo_full,
    output logic                  push,
    output entry_t                push_data,
    output logic [SCALE_W-1:0]    time_scale
);

    logic               paused_reg, paused_next;
    logic [DELTA_W-1:0] max_delta_reg, max_delta_next;
    logic [SCALE_W-1:0] time_scale_reg, time_scale_next;
    logic [DELTA_W-1:0] raw_delta;

    // register writes
    always_comb begin
        paused_next     = paused_reg;
        max_delta_next  = max_delta_reg;
        time_scale_next = time_scale_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx)
                REG_PAUSED:     paused_next     = cfg_wdata[0];
                REG_MAX_DELTA:  max_delta_next  = cfg_wdata;
                REG_TIME_SCALE: time_scale_next = cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paused_reg     <= 1'b0;
            max_delta_reg  <= MAX_DELTA_RST;
            time_scale_reg <= TIME_SCALE_RST;
        end else begin
            paused_reg     <= paused_next;
            max_delta_reg  <= max_delta_next;
            time_scale_reg <= time_scale_next;
        end
    end

    // accept whenever the command queue has room
    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    // classify: pause and clamp the delta, mask the tag
    always_comb begin
        raw_delta = paused_reg ? '0 : s_data.delta_time;
        push_data.opcode     = s_data.opcode;
        push_data.delta      = (raw_delta > max_delta_reg) ? max_delta_reg : raw_delta;
        push_data.time_value = s_data.time_value;
        push_data.tag        = tag_store(s_data.event_tag);
    end

    assign time_scale = time_scale_reg;

endmodule

// File: rtl/core/sctq_fifo.sv
// short command queue between front and back end
module sctq_fifo import sctq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/sctq_evq.sv
// sorted event queue: a row of cells with parallel insert and shift-down pop
module sctq_evq import sctq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  evq_ctrl_t           ctrl,
    input  logic [TIME_W-1:0]   ins_time,
    input  logic [TAG_BITS-1:0] ins_tag,
    output evq_view_t           view
);

    logic [TIME_W-1:0]      time_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0]      time_next [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    tag_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    tag_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] later;

    // each live cell flags a time strictly later than the new event
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            later[i] = (CNT_W'(i) < count_reg) && (time_reg[i] > ins_time);
        end
    end

    // insert shifts the later cells up one; pop shifts all cells down one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            time_next[i] = time_reg[i];
            tag_next[i]  = tag_reg[i];
        end
        count_next = count_reg;
        priority if (ctrl.ins) begin
            if (later[0] || count_reg == '0) begin
                time_next[0] = ins_time;
                tag_next[0]  = ins_tag;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (later[i-1]) begin
                    time_next[i] = time_reg[i-1];
                    tag_next[i]  = tag_reg[i-1];
                end else if (later[i] || CNT_W'(i) == count_reg) begin
                    time_next[i] = ins_time;
                    tag_next[i]  = ins_tag;
                end
            end
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                time_next[i] = time_reg[i+1];
                tag_next[i]  = tag_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // cell payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            time_reg[i] <= time_next[i];
            tag_reg[i]  <= tag_next[i];
        end
    end

    // head and runner-up for the back end
    always_comb begin
        view.count     = count_reg;
        view.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
        view.head_time = time_reg[0];
        view.head_tag  = tag_reg[0];
        view.next_time = time_reg[1];
    end

endmodule

// File: rtl/core/sctq_back.sv
// back end: clock update, event firing and posting, result register
module sctq_back import sctq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  entry_t              fifo_head,
    input  logic                fifo_empty,
    output logic                fifo_pop,
    input  logic [SCALE_W-1:0]  time_scale,
    input  evq_view_t           view,
    output evq_ctrl_t           evq_ctrl,
    output logic [TIME_W-1:0]   ins_time,
    output logic [TAG_BITS-1:0] ins_tag,
    output logic                m_valid,
    input  logic                m_ready,
    output res_t                m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_FIRE = 3'd3;
    localparam logic [2:0] ST_TIME = 3'd4;
    localparam logic [2:0] ST_INS  = 3'd5;
    localparam logic [2:0] ST_SET  = 3'd6;

    logic [2:0]        state_reg, state_next;
    entry_t            cmd_reg, cmd_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [STEP_W-1:0] last_delta_reg, last_delta_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;
    logic              out_free;
    logic              head_due;
    logic              next_due;
    logic [STEP_W-1:0] step;

    assign out_free = !m_valid_reg || m_ready;
    assign head_due = (view.count != '0) && (view.head_time <= elapsed_reg);
    assign next_due = (view.count > CNT_W'(1)) && (view.next_time <= elapsed_reg);
    assign step     = prod_reg[PROD_W-1:8];
    assign ins_time = t_reg;
    assign ins_tag  = cmd_reg.tag;

    // command sequencer
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        prod_next       = prod_reg;
        t_next          = t_reg;
        elapsed_next    = elapsed_reg;
        last_delta_next = last_delta_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        fifo_pop        = 1'b0;
        evq_ctrl        = '0;

        unique case (state_reg)
            // take the next command
            ST_IDLE: begin
                if (!fifo_empty) begin
                    fifo_pop = 1'b1;
                    cmd_next = fifo_head;
                    unique case (fifo_head.opcode)
                        OP_ADVANCE:  state_next = ST_MUL;
                        OP_SET_TIME: state_next = ST_SET;
                        default:     state_next = ST_TIME;
                    endcase
                end
            end
            // scale the clamped delta
            ST_MUL: begin
                prod_next  = PROD_W'(cmd_reg.delta) * PROD_W'(time_scale);
                state_next = ST_ADD;
            end
            // add the scaled step to the clock
            ST_ADD: begin
                last_delta_next = step;
                elapsed_next    = sat_add48(elapsed_reg, TIME_W'(step));
                state_next      = ST_FIRE;
            end
            // fire due events one per cycle while the output register is free, or report none due
            ST_FIRE: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.elapsed_now   = elapsed_reg;
                    m_data_next.applied_delta = TIME_W'(last_delta_reg);
                    m_data_next.status        = 1'b0;
                    if (head_due) begin
                        evq_ctrl.pop            = 1'b1;
                        m_data_next.event_fired = 1'b1;
                        m_data_next.fired_tag   = tag_out(view.head_tag);
                        m_data_next.last        = !next_due;
                        if (!next_due) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_data_next.event_fired = 1'b0;
                        m_data_next.fired_tag   = '0;
                        m_data_next.last        = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end
            end
            // work out the fire time of a post
            ST_TIME: begin
                t_next     = (cmd_reg.opcode == OP_POST_AFTER) ?
                             sat_add48(elapsed_reg, cmd_reg.time_value) :
                             cmd_reg.time_value;
                state_next = ST_INS;
            end
            // insert the event, or drop it when the queue is full
            ST_INS: begin
                if (out_free) begin
                    evq_ctrl.ins              = !view.full;
                    m_valid_next              = 1'b1;
                    m_data_next.event_fired   = 1'b0;
                    m_data_next.fired_tag     = '0;
                    m_data_next.elapsed_now   = elapsed_reg;
                    m_data_next.applied_delta = TIME_W'(last_delta_reg);
                    m_data_next.status        = view.full;
                    m_data_next.last          = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            // load a new clock value
            ST_SET: begin
                if (out_free) begin
                    elapsed_next              = cmd_reg.time_value;
                    m_valid_next              = 1'b1;
                    m_data_next.event_fired   = 1'b0;
                    m_data_next.fired_tag     = '0;
                    m_data_next.elapsed_now   = cmd_reg.time_value;
                    m_data_next.applied_delta = TIME_W'(last_delta_reg);
                    m_data_next.status        = 1'b0;
                    m_data_next.last          = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            elapsed_reg    <= '0;
            last_delta_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            last_delta_reg <= last_delta_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        prod_reg   <= prod_next;
        t_reg      <= t_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/scaled_clock_event_timer_queue.sv
// top level of the scaled clock event timer queue
// A scaled game clock with a sorted queue of up to QUEUE_DEPTH timed events. Commands are
// accepted into a two-word command queue, so the input side keeps taking words while the
// back end works, until that queue is full. The back end runs one command at a time: an
// advance scales the clamped delta, adds the step to the clock, then fires one due event
// per cycle while the output register is free, popping the event queue head, or reports
// none due; a post works out the fire time, then inserts in parallel; a set time loads the
// clock. Results wait in an output register; the back end stalls only while it is full.
// The user writes configuration through a plain write port only while the block is idle;
// the block does not enforce this. paused and max_delta act on commands accepted after a write.
module scaled_clock_event_timer_queue import sctq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cmd_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_data
);

    logic                fifo_full;
    logic                fifo_empty;
    logic                push;
    entry_t              push_data;
    logic                pop;
    entry_t              fifo_head;
    logic [SCALE_W-1:0]  time_scale;
    evq_ctrl_t           evq_ctrl;
    evq_view_t           view;
    logic [TIME_W-1:0]   ins_time;
    logic [TAG_BITS-1:0] ins_tag;

    // accept and classify
    sctq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data),
        .time_scale (time_scale)
    );

    // command queue
    sctq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (fifo_head),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    // sorted event store
    sctq_evq u_evq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (evq_ctrl),
        .ins_time (ins_time),
        .ins_tag  (ins_tag),
        .view     (view)
    );

    // execute commands
    sctq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_head  (fifo_head),
        .fifo_empty (fifo_empty),
        .fifo_pop   (pop),
        .time_scale (time_scale),
        .view       (view),
        .evq_ctrl   (evq_ctrl),
        .ins_time   (ins_time),
        .ins_tag    (ins_tag),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
